>>> sv/kic_pkg.sv
// Shared constants, types and helpers for the keypad integer calculator.
`timescale 1ns / 1ps
package kic_pkg;

  localparam int OW       = 32;            // operand width
  localparam int FB       = 16;            // fraction bits of the result
  localparam int RES_W    = 48;            // result width
  localparam int KEY_W    = 8;
  localparam int DLY_W    = 16;
  localparam int QW       = OW + FB;       // divide dividend / quotient width
  localparam int ALU_W    = OW + FB + 1;   // shared adder width
  localparam int CNT_W    = $clog2(QW + 1);
  localparam int SAT_CW   = (ALU_W > RES_W) ? ALU_W : RES_W;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [DLY_W-1:0] REPEAT_RESET = DLY_W'(350);
  localparam logic [DLY_W-1:0] DLY_MAX      = '1;
  localparam logic [3:0]       TEN          = 4'd10;

  localparam logic [KEY_W-1:0] KEY_NONE = 8'h00;
  localparam logic [KEY_W-1:0] KEY_0    = 8'h30;
  localparam logic [KEY_W-1:0] KEY_9    = 8'h39;
  localparam logic [KEY_W-1:0] KEY_ADD  = 8'h41;  // 'A'
  localparam logic [KEY_W-1:0] KEY_SUB  = 8'h42;  // 'B'
  localparam logic [KEY_W-1:0] KEY_DIV  = 8'h43;  // 'C'
  localparam logic [KEY_W-1:0] KEY_MUL  = 8'h2A;  // '*'
  localparam logic [KEY_W-1:0] KEY_EQ   = 8'h23;  // '#'
  localparam logic [KEY_W-1:0] CH_NONE  = 8'h00;
  localparam logic [KEY_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [KEY_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [KEY_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [KEY_W-1:0] CH_STAR  = 8'h2A;

  localparam logic [ADDR_W-3:0] REG_REPEAT = '0;

  typedef enum logic [2:0] {
    OPC_NONE = 3'd0,
    OPC_ADD  = 3'd1,
    OPC_SUB  = 3'd2,
    OPC_DIV  = 3'd3,
    OPC_MUL  = 3'd4
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIG_MUL,
    S_DIG_ADD,
    S_ADDSUB,
    S_MUL,
    S_NEG_A,
    S_NEG_B,
    S_DIV,
    S_DIV_SIGN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
  } eng_cmd_t;

  typedef struct packed {
    logic             busy;
    logic             load;
    logic [KEY_W-1:0] echo_key;
    logic [KEY_W-1:0] display_char;
    logic             display_cleared;
    logic             result_valid;
    logic [RES_W-1:0] result_value;
    logic             divide_by_zero;
  } eng_stat_t;

  function automatic logic [RES_W-1:0] sat_res(input logic signed [ALU_W-1:0] v);
    logic signed [SAT_CW-1:0] w;
    logic signed [SAT_CW-1:0] mx;
    logic signed [SAT_CW-1:0] mn;
    w  = SAT_CW'(v);
    mx = $signed((SAT_CW'(1) << (RES_W - 1)) - SAT_CW'(1));
    mn = -mx - SAT_CW'(1);
    if (w > mx) begin
      return mx[RES_W-1:0];
    end else if (w < mn) begin
      return mn[RES_W-1:0];
    end
    return w[RES_W-1:0];
  endfunction

endpackage

>>> sv/kic_alu.sv
// Shared add/subtract unit used by every arithmetic step.
`timescale 1ns / 1ps
module kic_alu (
  input  logic [kic_pkg::ALU_W-1:0] a,
  input  logic [kic_pkg::ALU_W-1:0] b,
  input  logic                      sub,
  output logic [kic_pkg::ALU_W-1:0] y
);

  assign y = a + (b ^ {kic_pkg::ALU_W{sub}}) + kic_pkg::ALU_W'(sub);

endmodule

>>> sv/kic_engine.sv
// Calculator sequencer: operand entry, operator decode and iterative arithmetic.
`timescale 1ns / 1ps
module kic_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  kic_pkg::eng_cmd_t  cmd,
  input  logic               out_free,
  output kic_pkg::eng_stat_t stat
);

  localparam int OW    = kic_pkg::OW;
  localparam int FB    = kic_pkg::FB;
  localparam int QW    = kic_pkg::QW;
  localparam int ALU_W = kic_pkg::ALU_W;
  localparam int CNT_W = kic_pkg::CNT_W;
  localparam int KEY_W = kic_pkg::KEY_W;

  kic_pkg::state_t  st_r, st_nxt;
  kic_pkg::opcode_t opc_r, opc_nxt;
  logic             new_entry_r, new_entry_nxt;
  logic [OW-1:0]    first_r, first_nxt;
  logic [OW-1:0]    second_r, second_nxt;
  logic             sel_sec_r, sel_sec_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [KEY_W-1:0] disp_r, disp_nxt;
  logic             clr_r, clr_nxt;
  logic             rvalid_r, rvalid_nxt;
  logic             dz_r, dz_nxt;
  logic             neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ALU_W-1:0] acc_r, acc_nxt;
  logic [QW-1:0]    aux_r, aux_nxt;
  logic [OW-1:0]    rem_r, rem_nxt;
  logic [OW-1:0]    dvs_r, dvs_nxt;

  logic [ALU_W-1:0] alu_a, alu_b, alu_y;
  logic             alu_sub;

  logic [OW-1:0]    cur_opnd;
  logic [OW-1:0]    wrap;
  logic [OW:0]      trial;
  logic             ge;
  logic [3:0]       digit;
  kic_pkg::opcode_t opc_eff;

  kic_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= kic_pkg::S_IDLE;
      opc_r       <= kic_pkg::OPC_NONE;
      new_entry_r <= 1'b1;
      first_r     <= '0;
      second_r    <= '0;
    end else begin
      st_r        <= st_nxt;
      opc_r       <= opc_nxt;
      new_entry_r <= new_entry_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_sec_r <= sel_sec_nxt;
    key_r     <= key_nxt;
    disp_r    <= disp_nxt;
    clr_r     <= clr_nxt;
    rvalid_r  <= rvalid_nxt;
    dz_r      <= dz_nxt;
    neg_r     <= neg_nxt;
    cnt_r     <= cnt_nxt;
    acc_r     <= acc_nxt;
    aux_r     <= aux_nxt;
    rem_r     <= rem_nxt;
    dvs_r     <= dvs_nxt;
  end

  always_comb begin
    st_nxt        = st_r;
    opc_nxt       = opc_r;
    new_entry_nxt = new_entry_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    sel_sec_nxt   = sel_sec_r;
    key_nxt       = key_r;
    disp_nxt      = disp_r;
    clr_nxt       = clr_r;
    rvalid_nxt    = rvalid_r;
    dz_nxt        = dz_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    aux_nxt       = aux_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;

    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;

    cur_opnd = sel_sec_r ? second_r : first_r;
    digit    = 4'(key_r - kic_pkg::KEY_0);
    trial    = {rem_r, aux_r[QW-1]};
    ge       = 1'b0;
    wrap     = alu_y[OW-1:0];
    opc_eff  = new_entry_r ? kic_pkg::OPC_NONE : opc_r;

    stat.busy            = (st_r != kic_pkg::S_IDLE);
    stat.load            = 1'b0;
    stat.echo_key        = key_r;
    stat.display_char    = disp_r;
    stat.display_cleared = clr_r;
    stat.result_valid    = rvalid_r;
    stat.result_value    = rvalid_r ? kic_pkg::sat_res(acc_r) : '0;
    stat.divide_by_zero  = dz_r;

    unique case (st_r)
      kic_pkg::S_IDLE: begin
        if (cmd.start) begin
          key_nxt    = cmd.key;
          clr_nxt    = new_entry_r;
          disp_nxt   = kic_pkg::CH_NONE;
          rvalid_nxt = 1'b0;
          dz_nxt     = 1'b0;
          acc_nxt    = '0;
          st_nxt     = kic_pkg::S_FINISH;
          if (new_entry_r) begin
            new_entry_nxt = 1'b0;
            first_nxt     = '0;
            second_nxt    = '0;
            opc_nxt       = kic_pkg::OPC_NONE;
          end
          if (cmd.key >= kic_pkg::KEY_0 && cmd.key <= kic_pkg::KEY_9) begin
            sel_sec_nxt = (opc_eff != kic_pkg::OPC_NONE);
            disp_nxt    = cmd.key;
            st_nxt      = kic_pkg::S_DIG_MUL;
          end else if (opc_eff != kic_pkg::OPC_NONE) begin
            if (cmd.key == kic_pkg::KEY_EQ) begin
              rvalid_nxt    = 1'b1;
              new_entry_nxt = 1'b1;
              unique case (opc_eff) inside
                kic_pkg::OPC_ADD, kic_pkg::OPC_SUB: st_nxt = kic_pkg::S_ADDSUB;
                kic_pkg::OPC_MUL: begin
                  aux_nxt = QW'(second_r);
                  dvs_nxt = first_r;
                  cnt_nxt = CNT_W'(OW);
                  st_nxt  = kic_pkg::S_MUL;
                end
                kic_pkg::OPC_DIV: begin
                  if (second_r == '0) begin
                    dz_nxt = 1'b1;
                  end else begin
                    st_nxt = kic_pkg::S_NEG_A;
                  end
                end
                default: st_nxt = kic_pkg::S_FINISH;
              endcase
            end
          end else begin
            unique case (cmd.key)
              kic_pkg::KEY_ADD: begin
                opc_nxt  = kic_pkg::OPC_ADD;
                disp_nxt = kic_pkg::CH_PLUS;
              end
              kic_pkg::KEY_SUB: begin
                opc_nxt  = kic_pkg::OPC_SUB;
                disp_nxt = kic_pkg::CH_MINUS;
              end
              kic_pkg::KEY_DIV: begin
                opc_nxt  = kic_pkg::OPC_DIV;
                disp_nxt = kic_pkg::CH_SLASH;
              end
              kic_pkg::KEY_MUL: begin
                opc_nxt  = kic_pkg::OPC_MUL;
                disp_nxt = kic_pkg::CH_STAR;
              end
              default: disp_nxt = kic_pkg::CH_NONE;
            endcase
          end
        end
      end

      kic_pkg::S_DIG_MUL: begin
        // x*10 = x*8 + x*2
        alu_a   = ALU_W'(cur_opnd) << 3;
        alu_b   = ALU_W'(cur_opnd) << 1;
        acc_nxt = alu_y;
        st_nxt  = kic_pkg::S_DIG_ADD;
      end

      kic_pkg::S_DIG_ADD: begin
        alu_a = acc_r;
        alu_b = ALU_W'(digit);
        if (sel_sec_r) begin
          second_nxt = wrap;
        end else begin
          first_nxt = wrap;
        end
        acc_nxt = '0;
        st_nxt  = kic_pkg::S_FINISH;
      end

      kic_pkg::S_ADDSUB: begin
        alu_a   = ALU_W'(first_r);
        alu_b   = ALU_W'(second_r);
        alu_sub = (opc_r == kic_pkg::OPC_SUB);
        acc_nxt = {{(ALU_W-OW){wrap[OW-1]}}, wrap} << FB;
        st_nxt  = kic_pkg::S_FINISH;
      end

      kic_pkg::S_MUL: begin
        // shift-add, low OW bits only
        alu_a   = acc_r;
        alu_b   = aux_r[0] ? ALU_W'(dvs_r) : '0;
        aux_nxt = aux_r >> 1;
        dvs_nxt = dvs_r << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          acc_nxt = {{(ALU_W-OW){wrap[OW-1]}}, wrap} << FB;
          st_nxt  = kic_pkg::S_FINISH;
        end else begin
          acc_nxt = alu_y;
        end
      end

      kic_pkg::S_NEG_A: begin
        alu_b   = ALU_W'(first_r);
        alu_sub = first_r[OW-1];
        alu_a   = first_r[OW-1] ? '0 : ALU_W'(first_r);
        if (!first_r[OW-1]) begin
          alu_b = '0;
        end
        aux_nxt = QW'(wrap) << FB;
        neg_nxt = first_r[OW-1];
        st_nxt  = kic_pkg::S_NEG_B;
      end

      kic_pkg::S_NEG_B: begin
        alu_b   = ALU_W'(second_r);
        alu_sub = second_r[OW-1];
        alu_a   = second_r[OW-1] ? '0 : ALU_W'(second_r);
        if (!second_r[OW-1]) begin
          alu_b = '0;
        end
        dvs_nxt = wrap;
        neg_nxt = neg_r ^ second_r[OW-1];
        rem_nxt = '0;
        cnt_nxt = CNT_W'(QW);
        st_nxt  = kic_pkg::S_DIV;
      end

      kic_pkg::S_DIV: begin
        // restoring division, one quotient bit per cycle
        alu_a   = ALU_W'(trial);
        alu_b   = ALU_W'(dvs_r);
        alu_sub = 1'b1;
        ge      = !alu_y[ALU_W-1];
        rem_nxt = ge ? alu_y[OW-1:0] : trial[OW-1:0];
        aux_nxt = {aux_r[QW-2:0], ge};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          st_nxt = kic_pkg::S_DIV_SIGN;
        end
      end

      kic_pkg::S_DIV_SIGN: begin
        alu_a   = neg_r ? '0 : ALU_W'(aux_r);
        alu_b   = neg_r ? ALU_W'(aux_r) : '0;
        alu_sub = neg_r;
        acc_nxt = alu_y;
        st_nxt  = kic_pkg::S_FINISH;
      end

      kic_pkg::S_FINISH: begin
        if (out_free) begin
          stat.load = 1'b1;
          st_nxt    = kic_pkg::S_IDLE;
        end
      end

      default: st_nxt = kic_pkg::S_IDLE;
    endcase
  end

endmodule

>>> sv/keypad_integer_calculator_top.sv
// Top level: register port, key filter, calculator engine and result register.
`timescale 1ns / 1ps
// Keypad calculator. Ticks and rejected keypad samples do not start the engine
// and give no result. An accepted key occupies the engine, which holds
// in_stall high until its result word is loaded into the output register:
// digit keys run a multiply-by-ten and a digit add, other keys go straight
// to finish, '#' with add or subtract runs an add, with multiply a shift-add
// (one bit per cycle through the shared adder), with divide sign handling and
// a 48-bit restoring divide (one quotient bit per cycle on the same adder);
// zero divisor skips to finish, which waits while output is full and stalled.
// The repeat delay register sits at byte address 0, reset value 350.
module keypad_integer_calculator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic [kic_pkg::KEY_W-1:0]         in_key,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [kic_pkg::KEY_W-1:0]         out_echo_key,
  output logic [kic_pkg::KEY_W-1:0]         out_display_char,
  output logic                              out_display_cleared,
  output logic                              out_result_valid,
  output logic signed [kic_pkg::RES_W-1:0]  out_result_value,
  output logic                              out_divide_by_zero,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kic_pkg::ADDR_W-1:0]        paddr,
  input  logic [kic_pkg::DATA_W-1:0]        pwdata,
  output logic [kic_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  localparam int KEY_W = kic_pkg::KEY_W;
  localparam int DLY_W = kic_pkg::DLY_W;

  logic [DLY_W-1:0] repeat_r, repeat_nxt;
  logic [KEY_W-1:0] last_r, last_nxt;
  logic [DLY_W-1:0] dly_r, dly_nxt;
  logic             ov_r, ov_nxt;

  logic [KEY_W-1:0]         echo_r;
  logic [KEY_W-1:0]         disp_r;
  logic                     clr_r;
  logic                     rv_r;
  logic [kic_pkg::RES_W-1:0] val_r;
  logic                     dz_r;

  kic_pkg::eng_cmd_t  cmd;
  kic_pkg::eng_stat_t stat;
  logic               take;
  logic               wr;
  logic               out_free;

  assign pready   = 1'b1;
  assign wr       = psel && penable && pwrite &&
                    (paddr[kic_pkg::ADDR_W-1:2] == kic_pkg::REG_REPEAT);
  assign prdata   = (paddr[kic_pkg::ADDR_W-1:2] == kic_pkg::REG_REPEAT) ?
                    kic_pkg::DATA_W'(repeat_r) : '0;

  assign in_stall = stat.busy;
  assign take     = in_valid && !in_stall;
  assign out_free = !ov_r || !out_stall;

  kic_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .out_free (out_free),
    .stat     (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_r <= kic_pkg::REPEAT_RESET;
      last_r   <= kic_pkg::KEY_NONE;
      dly_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      repeat_r <= repeat_nxt;
      last_r   <= last_nxt;
      dly_r    <= dly_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.load) begin
      echo_r <= stat.echo_key;
      disp_r <= stat.display_char;
      clr_r  <= stat.display_cleared;
      rv_r   <= stat.result_valid;
      val_r  <= stat.result_value;
      dz_r   <= stat.divide_by_zero;
    end
  end

  always_comb begin
    repeat_nxt = wr ? pwdata[DLY_W-1:0] : repeat_r;
    last_nxt   = last_r;
    dly_nxt    = dly_r;
    cmd.start  = 1'b0;
    cmd.key    = in_key;
    if (take) begin
      if (!in_op) begin
        if (dly_r != kic_pkg::DLY_MAX) begin
          dly_nxt = dly_r + DLY_W'(1);
        end
      end else begin
        last_nxt = in_key;
        if (in_key != kic_pkg::KEY_NONE &&
            !(in_key == last_r && dly_r < repeat_r)) begin
          dly_nxt   = '0;
          cmd.start = 1'b1;
        end
      end
    end
    if (stat.load) begin
      ov_nxt = 1'b1;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  assign out_valid           = ov_r;
  assign out_echo_key        = echo_r;
  assign out_display_char    = disp_r;
  assign out_display_cleared = clr_r;
  assign out_result_valid    = rv_r;
  assign out_result_value    = $signed(val_r);
  assign out_divide_by_zero  = dz_r;

endmodule

>>> tb/sv/kic_calc_checker.sv
// Checker for the keypad calculator: mirrors it from accepted words and compares results.
`timescale 1ns / 1ps
module kic_calc_checker
  import kic_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    in_op,
  input  logic [KEY_W-1:0]        in_key,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [KEY_W-1:0]        out_echo_key,
  input  logic [KEY_W-1:0]        out_display_char,
  input  logic                    out_display_cleared,
  input  logic                    out_result_valid,
  input  logic signed [RES_W-1:0] out_result_value,
  input  logic                    out_divide_by_zero,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  input  logic                    pready,
  output int                      errors,
  output int                      pending
);

  typedef struct packed {
    logic [KEY_W-1:0] echo_key;
    logic [KEY_W-1:0] display_char;
    logic             display_cleared;
    logic             result_valid;
    logic [RES_W-1:0] result_value;
    logic             divide_by_zero;
  } calc_word_t;

  calc_word_t       calc_q[$];
  calc_word_t       exp_w;
  logic [KEY_W-1:0] last_key;
  logic [DLY_W-1:0] tick_count;
  logic [DLY_W-1:0] repeat_ticks;
  logic [OW-1:0]    opnd_a;
  logic [OW-1:0]    opnd_b;
  opcode_t          opc;
  logic             fresh;
  int               err_count = 0;

  function automatic longint clamp_res(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (RES_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  function automatic logic [RES_W-1:0] eval_result(input opcode_t o, input logic [OW-1:0] a,
                                                   input logic [OW-1:0] b, output logic dz);
    logic [OW-1:0]        w;
    logic signed [OW-1:0] sa;
    logic signed [OW-1:0] sb;
    longint               v;
    longint               scale;
    scale = longint'(1) <<< FB;
    sa    = a;
    sb    = b;
    dz    = 1'b0;
    v     = 0;
    case (o)
      OPC_ADD: begin
        w = a + b;
        v = longint'($signed(w)) * scale;
      end
      OPC_SUB: begin
        w = a - b;
        v = longint'($signed(w)) * scale;
      end
      OPC_MUL: begin
        w = a * b;
        v = longint'($signed(w)) * scale;
      end
      OPC_DIV: begin
        if (sb == 0) begin
          dz = 1'b1;
        end else begin
          v = (longint'(sa) * scale) / longint'(sb);
        end
      end
      default: v = 0;
    endcase
    v = clamp_res(v);
    return v[RES_W-1:0];
  endfunction

  task automatic calc_step(input logic op, input logic [KEY_W-1:0] key);
    calc_word_t w;
    logic       dz;
    if (!op) begin
      if (tick_count != DLY_MAX) tick_count = tick_count + 1'b1;
      return;
    end
    if (key == KEY_NONE || (key == last_key && tick_count < repeat_ticks)) begin
      last_key = key;
      return;
    end
    last_key   = key;
    tick_count = '0;
    w          = '0;
    w.echo_key = key;
    if (fresh) begin
      fresh             = 1'b0;
      w.display_cleared = 1'b1;
      opnd_a            = '0;
      opnd_b            = '0;
      opc               = OPC_NONE;
    end
    if (key >= KEY_0 && key <= KEY_9) begin
      if (opc == OPC_NONE) begin
        opnd_a = opnd_a * OW'(TEN) + OW'(key - KEY_0);
      end else begin
        opnd_b = opnd_b * OW'(TEN) + OW'(key - KEY_0);
      end
      w.display_char = key;
    end else if (opc != OPC_NONE) begin
      if (key == KEY_EQ) begin
        w.result_value   = eval_result(opc, opnd_a, opnd_b, dz);
        w.divide_by_zero = dz;
        w.result_valid   = 1'b1;
        fresh            = 1'b1;
      end
    end else begin
      case (key)
        KEY_ADD: begin
          opc            = OPC_ADD;
          w.display_char = CH_PLUS;
        end
        KEY_SUB: begin
          opc            = OPC_SUB;
          w.display_char = CH_MINUS;
        end
        KEY_DIV: begin
          opc            = OPC_DIV;
          w.display_char = CH_SLASH;
        end
        KEY_MUL: begin
          opc            = OPC_MUL;
          w.display_char = CH_STAR;
        end
        default: ;
      endcase
    end
    calc_q.push_back(w);
  endtask

  function automatic void check_field(input string name, input logic [RES_W-1:0] want,
                                      input logic [RES_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      last_key     = KEY_NONE;
      tick_count   = '0;
      repeat_ticks = REPEAT_RESET;
      opnd_a       = '0;
      opnd_b       = '0;
      opc          = OPC_NONE;
      fresh        = 1'b1;
      calc_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (calc_q.size() == 0) begin
          $error("result word with nothing expected: echo_key %h", out_echo_key);
          err_count++;
        end else begin
          exp_w = calc_q.pop_front();
          check_field("echo_key", RES_W'(exp_w.echo_key), RES_W'(out_echo_key));
          check_field("display_char", RES_W'(exp_w.display_char), RES_W'(out_display_char));
          check_field("display_cleared", RES_W'(exp_w.display_cleared),
                      RES_W'(out_display_cleared));
          check_field("result_valid", RES_W'(exp_w.result_valid), RES_W'(out_result_valid));
          check_field("result_value", exp_w.result_value, out_result_value);
          check_field("divide_by_zero", RES_W'(exp_w.divide_by_zero),
                      RES_W'(out_divide_by_zero));
        end
      end
      if (in_valid && !in_stall) calc_step(in_op, in_key);
      if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_REPEAT) begin
        repeat_ticks = pwdata[DLY_W-1:0];
      end
    end
    errors  <= err_count;
    pending <= calc_q.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top: clock, reset, keypad and register stimulus, result sink and verdict.
`timescale 1ns / 1ps
module tb_top;
  import kic_pkg::*;

  localparam logic [ADDR_W-1:0] REPEAT_ADDR   = {REG_REPEAT, 2'b00};
  localparam logic [KEY_W-1:0]  KEY_OTHER     = 8'h58;
  localparam logic [KEY_W-1:0]  KEY_MAX       = 8'hFF;
  localparam logic [KEY_W-1:0]  KEY_HELD      = 8'h35;
  localparam int                GAP_MAX       = 19;
  localparam int                LONG_HOLD     = 400;
  localparam int                SETTLE_CYCLES = 100;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_op;
  logic [KEY_W-1:0]        in_key;
  logic                    out_valid;
  logic                    out_stall;
  logic [KEY_W-1:0]        out_echo_key;
  logic [KEY_W-1:0]        out_display_char;
  logic                    out_display_cleared;
  logic                    out_result_valid;
  logic signed [RES_W-1:0] out_result_value;
  logic                    out_divide_by_zero;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ADDR_W-1:0]       paddr;
  logic [DATA_W-1:0]       pwdata;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  int               fail_count;
  int               words_due;
  int               keys_sent;
  int               gap_max;
  int               cur_delay;
  int               rx_calm;
  int               hold_reqs;
  logic [KEY_W-1:0] sent_last;

  logic [KEY_W-1:0] op_keys[4]     = '{KEY_ADD, KEY_SUB, KEY_DIV, KEY_MUL};
  longint unsigned  corner_vals[5] = '{64'd0, 64'd1, 64'd2147483647, 64'd2147483648,
                                       64'd4294967295};

  keypad_integer_calculator_top dut (.*);

  kic_calc_checker chk (.*, .errors(fail_count), .pending(words_due));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("** keypad_integer_calculator_top: FAILED **");
    $finish;
  end

  task automatic send_word(input logic op, input logic [KEY_W-1:0] key);
    int n;
    n = $urandom_range(0, gap_max);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_key   <= key;
    if (op) sent_last = key;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_tick();
    send_word(1'b0, KEY_W'($urandom));
  endtask

  // release first so a repeated digit is not filtered as a held key
  task automatic press(input logic [KEY_W-1:0] key);
    if (key == sent_last) send_word(1'b1, KEY_NONE);
    send_word(1'b1, key);
    keys_sent++;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_tick();
    end
  endtask

  task automatic type_number(input longint unsigned n);
    string s;
    int    i;
    s = $sformatf("%0d", n);
    for (i = 0; i < s.len(); i++) press(s[i]);
  endtask

  task automatic type_operand();
    int r;
    int len;
    r = $urandom_range(0, 11);
    if (r == 0) begin
      type_number(corner_vals[$urandom_range(0, 4)]);
    end else if (r != 1) begin
      len = (r == 2) ? $urandom_range(10, 12) : $urandom_range(1, 5);
      repeat (len) press(KEY_0 + KEY_W'($urandom_range(0, 9)));
    end
  endtask

  task automatic calc_seq();
    gap_max = ($urandom_range(0, 4) == 0) ? 0 : GAP_MAX;
    type_operand();
    press(op_keys[$urandom_range(0, 3)]);
    if ($urandom_range(0, 5) == 0) press(op_keys[$urandom_range(0, 3)]);
    type_operand();
    if ($urandom_range(0, 9) != 0) press(KEY_EQ);
  endtask

  task automatic hold_key(input logic [KEY_W-1:0] key);
    int max_t;
    max_t = (cur_delay <= 20) ? cur_delay + 2 : 5;
    press(key);
    repeat ($urandom_range(0, max_t)) send_tick();
    send_word(1'b1, key);
    keys_sent++;
  endtask

  task automatic random_phase(input int n);
    int target;
    int r;
    target = keys_sent + n;
    hold_reqs++;
    while (keys_sent < target) begin
      r = $urandom_range(0, 9);
      if ($urandom_range(0, 60) == 0) hold_reqs++;
      if (r < 7) begin
        calc_seq();
      end else if (r == 7) begin
        gap_max = GAP_MAX;
        repeat ($urandom_range(1, 6)) send_word(1'($urandom_range(0, 1)), KEY_W'($urandom));
      end else if (r == 8) begin
        hold_key(($urandom_range(0, 1) == 0) ? KEY_0 + KEY_W'($urandom_range(0, 9))
                                            : op_keys[$urandom_range(0, 3)]);
      end else begin
        repeat ($urandom_range(1, 20)) send_tick();
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input int v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REPEAT_ADDR;
    pwdata  <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    cur_delay = v;
  endtask

  // result sink: random stalls, quiet stretches, and a long hold-off on request
  initial begin : rx_proc
    int n;
    int holds_done;
    out_stall  = 1'b0;
    rx_calm    = 0;
    holds_done = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_reqs > holds_done) begin
        n = LONG_HOLD;
        holds_done++;
      end else if (rx_calm > 0) begin
        n = 0;
        rx_calm--;
      end else begin
        n = $urandom_range(0, GAP_MAX);
        if ($urandom_range(0, 15) == 0) rx_calm = $urandom_range(5, 30);
      end
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_op     = 1'b0;
    in_key    = KEY_NONE;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    hold_reqs = 0;
    gap_max   = GAP_MAX;
    keys_sent = 0;
    sent_last = KEY_NONE;
    cur_delay = int'(REPEAT_RESET);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: equals and other keys before any operator, key extremes, tick
    press(KEY_EQ);
    press(KEY_OTHER);
    send_word(1'b1, KEY_MAX);
    send_word(1'b1, KEY_NONE);
    send_word(1'b0, KEY_MAX);
    // divide by zero
    type_number(90);
    press(KEY_DIV);
    press(KEY_0);
    press(KEY_EQ);
    // second operator is ignored
    type_number(5);
    press(KEY_ADD);
    press(KEY_SUB);
    type_number(3);
    press(KEY_EQ);
    type_number(8);
    press(KEY_MUL);
    type_number(7);
    press(KEY_EQ);
    // held key within the repeat delay is dropped
    press(KEY_HELD);
    send_word(1'b1, KEY_HELD);
    // most negative over minus one saturates
    type_number(64'd2147483648);
    press(KEY_DIV);
    type_number(64'd4294967295);
    press(KEY_EQ);
    settle();

    cfg_write(0);
    random_phase(250);
    settle();

    cfg_write($urandom_range(1, 6));
    random_phase(250);
    settle();

    // full repeat delay: a held key stays filtered
    cfg_write(int'(DLY_MAX));
    gap_max = 0;
    press(KEY_HELD);
    send_word(1'b1, KEY_HELD);
    repeat (20) send_tick();
    send_word(1'b1, KEY_HELD);
    random_phase(150);
    settle();

    cfg_write($urandom_range(0, int'(DLY_MAX)));
    random_phase(150);
    settle();

    if (fail_count == 0) begin
      $display("** keypad_integer_calculator_top: PASSED **");
    end else begin
      $display("** keypad_integer_calculator_top: FAILED **");
    end
    $finish;
  end

endmodule
